// File: hdl/dmwbc_pkg.sv
package dmwbc_pkg;

  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;

  localparam int DEF_NUM_LINES      = 64;
  localparam int DEF_BYTES_PER_LINE = 4;
  localparam int DEF_MEMORY_BYTES   = 65536;

  localparam int IN_TDATA_W  = ((ADDR_W + BYTE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = BYTE_W;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WBACK,
    ST_FILL,
    ST_ACCESS,
    ST_RESP
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic hit_write;
    logic hit_read_out;
    logic wb_en;
    logic fill_en;
    logic access;
    logic miss_read_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic hit;
    logic victim_dirty;
    logic move_done;
    logic out_busy;
    logic is_write;
  } dp_stat_t;

endpackage

// File: hdl/dmwbc_ctrl.sv
module dmwbc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  dmwbc_pkg::dp_stat_t stat,
  output dmwbc_pkg::dp_cmd_t  cmd
);
  import dmwbc_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        priority if (!stat.hit) begin
          state_nxt = stat.victim_dirty ? ST_WBACK : ST_FILL;
        end else if (stat.is_write || !stat.out_busy) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_WBACK: begin
        if (stat.move_done) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (stat.move_done) state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        state_nxt = stat.is_write ? ST_IDLE : ST_RESP;
      end
      ST_RESP: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clear_en = 1'b1;
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_LOOKUP: begin
        cmd.hit_write    = stat.hit && stat.is_write;
        cmd.hit_read_out = stat.hit && !stat.is_write && !stat.out_busy;
      end
      ST_WBACK:  cmd.wb_en   = 1'b1;
      ST_FILL:   cmd.fill_en = 1'b1;
      ST_ACCESS: cmd.access  = 1'b1;
      ST_RESP:   cmd.miss_read_out = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/dmwbc_dpath.sv
module dmwbc_dpath #(
  parameter int NUM_LINES      = dmwbc_pkg::DEF_NUM_LINES,
  parameter int BYTES_PER_LINE = dmwbc_pkg::DEF_BYTES_PER_LINE,
  parameter int MEMORY_BYTES   = dmwbc_pkg::DEF_MEMORY_BYTES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dmwbc_pkg::dp_cmd_t                  cmd,
  output dmwbc_pkg::dp_stat_t                 stat,
  input  logic [dmwbc_pkg::ADDR_W-1:0]        in_address,
  input  logic                                in_action,
  input  logic [dmwbc_pkg::BYTE_W-1:0]        in_write_data,
  input  logic                                out_tready,
  output logic                                out_valid,
  output logic [dmwbc_pkg::BYTE_W-1:0]        out_read_data,
  output logic                                out_hit,
  output logic                                out_dirty
);
  import dmwbc_pkg::*;

  localparam int OW  = $clog2(BYTES_PER_LINE);
  localparam int IW  = $clog2(NUM_LINES);
  localparam int SW  = IW + OW;
  localparam int TW  = ADDR_W - SW;
  localparam int CW  = $clog2(BYTES_PER_LINE + 1);
  localparam int MAW = ($clog2(MEMORY_BYTES) < ADDR_W) ? $clog2(MEMORY_BYTES) : ADDR_W;
  localparam int MEM_DEPTH = 2 ** MAW;
  localparam int LM_DEPTH  = NUM_LINES * BYTES_PER_LINE;

  // Request
  logic [ADDR_W-1:0] addr_r;
  logic              act_r;
  logic [BYTE_W-1:0] wdata_r;

  logic [IW-1:0] idx_r;
  logic [TW-1:0] tag_r;
  logic [SW-1:0] slot_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r  <= in_address;
      act_r   <= in_action;
      wdata_r <= in_write_data;
    end
  end

  assign idx_r  = addr_r[OW +: IW];
  assign tag_r  = addr_r[ADDR_W-1 -: TW];
  assign slot_r = addr_r[SW-1:0];

  // Byte mover counter: each byte is written in the cycle after it is read
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          mv_en, rd_act, wr_act, move_done;
  logic [OW-1:0] rd_off, wr_off;

  assign mv_en     = cmd.wb_en | cmd.fill_en;
  assign move_done = (cnt_r == CW'(BYTES_PER_LINE));
  assign rd_act    = !move_done;
  assign wr_act    = (cnt_r != '0);
  assign rd_off    = cnt_r[OW-1:0];
  assign wr_off    = OW'(cnt_r - 1'b1);
  assign cnt_nxt   = (mv_en && !move_done) ? cnt_r + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Clearing sweep over backing memory
  logic [MAW-1:0] clr_r, clr_nxt;

  assign clr_nxt = cmd.clear_en ? clr_r + 1'b1 : clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  // Tag store: {dirty, tag}
  logic [TW:0]   tmem [NUM_LINES];
  logic [TW:0]   tag_rd_r;
  logic          tm_we;
  logic [TW:0]   tm_wdata;
  logic [IW-1:0] in_idx;

  assign in_idx   = in_address[OW +: IW];
  assign tm_we    = cmd.hit_write | cmd.access;
  assign tm_wdata = {(cmd.hit_write ? 1'b1 : act_r), tag_r};

  always_ff @(posedge clk) begin
    if (tm_we) tmem[idx_r] <= tm_wdata;
    if (cmd.accept) tag_rd_r <= tmem[in_idx];
  end

  // Valid bits
  logic [NUM_LINES-1:0] valid_r, valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.access) valid_nxt[idx_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Line data store
  logic [BYTE_W-1:0] lmem [LM_DEPTH];
  logic [BYTE_W-1:0] line_rd_r;
  logic [BYTE_W-1:0] mem_rd_r;
  logic              lm_we, lm_re;
  logic [SW-1:0]     lm_waddr, lm_raddr;
  logic [BYTE_W-1:0] lm_wdata;

  always_comb begin
    lm_we    = 1'b0;
    lm_waddr = slot_r;
    lm_wdata = wdata_r;
    priority if (cmd.fill_en && wr_act) begin
      lm_we    = 1'b1;
      lm_waddr = {idx_r, wr_off};
      lm_wdata = mem_rd_r;
    end else if (cmd.hit_write || (cmd.access && act_r == ACT_WRITE)) begin
      lm_we = 1'b1;
    end else begin
      lm_we = 1'b0;
    end
  end

  always_comb begin
    lm_re    = 1'b0;
    lm_raddr = slot_r;
    priority if (cmd.accept) begin
      lm_re    = 1'b1;
      lm_raddr = in_address[SW-1:0];
    end else if (cmd.wb_en && rd_act) begin
      lm_re    = 1'b1;
      lm_raddr = {idx_r, rd_off};
    end else if (cmd.access && act_r == ACT_READ) begin
      lm_re = 1'b1;
    end else begin
      lm_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lm_we) lmem[lm_waddr] <= lm_wdata;
    if (lm_re) line_rd_r <= lmem[lm_raddr];
  end

  // Backing memory; block addresses wrap at its size
  logic [BYTE_W-1:0] bmem [MEM_DEPTH];
  logic [ADDR_W-1:0] victim_addr, fill_addr;
  logic              bm_we, bm_re;
  logic [MAW-1:0]    bm_waddr;
  logic [BYTE_W-1:0] bm_wdata;

  assign victim_addr = {tag_rd_r[TW-1:0], idx_r, wr_off};
  assign fill_addr   = {tag_r, idx_r, rd_off};
  assign bm_we       = cmd.clear_en | (cmd.wb_en & wr_act);
  assign bm_waddr    = cmd.clear_en ? clr_r : victim_addr[MAW-1:0];
  assign bm_wdata    = cmd.clear_en ? '0 : line_rd_r;
  assign bm_re       = cmd.fill_en & rd_act;

  always_ff @(posedge clk) begin
    if (bm_we) bmem[bm_waddr] <= bm_wdata;
    if (bm_re) mem_rd_r <= bmem[fill_addr[MAW-1:0]];
  end

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_hit_r, out_dirty_r;
  logic              out_load;

  assign out_load      = cmd.hit_read_out | cmd.miss_read_out;
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r  <= line_rd_r;
      out_hit_r   <= cmd.hit_read_out;
      out_dirty_r <= cmd.hit_read_out & tag_rd_r[TW];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_hit       = out_hit_r;
  assign out_dirty     = out_dirty_r;

  // Status
  assign stat.clear_done   = &clr_r;
  assign stat.hit          = valid_r[idx_r] && (tag_rd_r[TW-1:0] == tag_r);
  assign stat.victim_dirty = valid_r[idx_r] & tag_rd_r[TW];
  assign stat.move_done    = move_done;
  assign stat.out_busy     = out_valid_r & ~out_tready;
  assign stat.is_write     = (act_r == ACT_WRITE);

endmodule

// File: hdl/direct_mapped_writeback_cache_unit.sv
// Direct-mapped write-back, write-allocate byte cache over a backing memory it
// holds itself. One transaction is one byte access; reads return one result
// (data, hit, dirty), writes return none. After reset the block sweeps the
// backing memory to zero, one byte a cycle (all 65536 bytes at the default size,
// 2**min(16, log2(MEMORY_BYTES)) in general), and accepts nothing until done.
// Items are handled one at a time. A hit needs only the lookup; a clean miss adds
// the line fill and the access, plus a result load for a read, and a dirty
// victim adds a write-back of the line before the fill. A read that finds the
// previous result still waiting holds until that result is taken. The line and
// backing memories move one byte per cycle, which sets the miss time. All
// parameters must be powers of two.
module direct_mapped_writeback_cache_unit #(
  parameter int NUM_LINES      = dmwbc_pkg::DEF_NUM_LINES,
  parameter int BYTES_PER_LINE = dmwbc_pkg::DEF_BYTES_PER_LINE,
  parameter int MEMORY_BYTES   = dmwbc_pkg::DEF_MEMORY_BYTES
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [15:0] address, [23:16] write_data
  input  logic [dmwbc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] action
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [7:0] read_data
  output logic [dmwbc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] hit, [1] dirty
  output logic [dmwbc_pkg::OUT_TUSER_W-1:0]     out_tuser
);
  import dmwbc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_hit, out_dirty;

  dmwbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dmwbc_dpath #(
    .NUM_LINES      (NUM_LINES),
    .BYTES_PER_LINE (BYTES_PER_LINE),
    .MEMORY_BYTES   (MEMORY_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_address    (in_tdata[ADDR_W-1:0]),
    .in_action     (in_tuser),
    .in_write_data (in_tdata[ADDR_W +: BYTE_W]),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_read_data (out_tdata),
    .out_hit       (out_hit),
    .out_dirty     (out_dirty)
  );

  assign out_tuser = {out_dirty, out_hit};

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("transaction accepted while previous one in flight");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hit_read_out || cmd.miss_read_out) |-> !stat.out_busy)
    else $error("result register overwritten while still pending");

  a_wback_then_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb_en && stat.move_done) |=> (cmd.fill_en && !stat.move_done))
    else $error("write-back not followed by a fresh fill");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_en |-> !in_tready)
    else $error("input ready during clearing sweep");
`endif

endmodule
